### hdl/mtts_pkg.sv
// Package with the transaction types and fixed constants of the move toward target step block.
package mtts_pkg;

  localparam int unsigned IN_COORD_W = 24;
  localparam int unsigned SPEED_W    = 24;
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned STEP_W     = 24;
  localparam int unsigned FRAC_SHIFT = 16;

  localparam logic [1:0] FUNC_PLACE = 2'd0;
  localparam logic [1:0] FUNC_GOTO  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0]                   func;
    logic signed [IN_COORD_W-1:0] target_x;
    logic signed [IN_COORD_W-1:0] target_y;
    logic [ELAPSED_W-1:0]         elapsed;
  } in_t;

  typedef struct packed {
    logic signed [IN_COORD_W-1:0] pos_x;
    logic signed [IN_COORD_W-1:0] pos_y;
    logic                         is_moving;
    logic                         arrived;
  } out_t;

endpackage

### hdl/move_toward_target_step_top.sv
// Top level of the move toward target step block: sequencer, shared multiplier, root and divider.
//
// Usage: commands arrive on the input channel (valid/ready) and each one gives exactly one
// result transaction on the output channel (valid/ready). The speed register is written
// through cfg_we_i/cfg_wdata_i; the user must write it only while the block is idle, since
// the block itself does not enforce this. Place, go-to, no-op and ticks while stopped go
// from acceptance straight to the result state, which loads the output register. A tick
// while moving runs one shared multiplier for the step and the two squares, then a
// digit-by-digit square root. If the destination is within the step, the point moves onto
// it; otherwise a restoring divider runs for the x axis and then for the y axis before the
// result state.
// One command is worked on at a time; the next one is accepted once the sequencer is back in
// its idle state, even while the previous result still waits in the output register.
// When the receiver stalls, a finished command holds in its last state until the output
// register frees.
// Reset clears the position, the destination, the moving flag and the speed to zero and
// empties the output register.
module move_toward_target_step_top
  import mtts_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               cfg_we_i,
  input  logic [SPEED_W-1:0] cfg_wdata_i
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned RW   = CW + 1;
  localparam int unsigned MW   = (CW > STEP_W) ? CW : STEP_W;
  localparam int unsigned PW   = 2 * MW;
  localparam int unsigned SW   = 2 * CW + 1;
  localparam int unsigned RADW = 2 * RW;
  localparam int unsigned NW   = CW + STEP_W;
  localparam int unsigned ITW  = (RW > STEP_W) ? RW : STEP_W;
  localparam int unsigned CNTW = $clog2(ITW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MSTEP = 4'd1;
  localparam logic [3:0] S_MSQX  = 4'd2;
  localparam logic [3:0] S_MSQY  = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_LDX   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_MULY  = 4'd9;
  localparam logic [3:0] S_LDY   = 4'd10;
  localparam logic [3:0] S_RES   = 4'd11;

  logic [3:0]           state_q;
  logic [CNTW-1:0]      cnt_q;
  logic                 div_y_q;
  logic                 out_valid_q;
  logic signed [CW-1:0] cur_x_q, cur_y_q, dest_x_q, dest_y_q;
  logic                 moving_q;
  logic [SPEED_W-1:0]   speed_q;

  logic [PW-1:0]        prod_q;
  logic [STEP_W-1:0]    step_q;
  logic [CW-1:0]        ax_q, ay_q;
  logic                 negx_q, negy_q;
  logic [ELAPSED_W-1:0] elapsed_q;
  logic [SW-1:0]        sum_q;
  logic [RADW-1:0]      rad_q;
  logic [RW-1:0]        root_q;
  logic [RW+1:0]        sqrem_q;
  logic [RW-1:0]        drem_q;
  logic [STEP_W-1:0]    nlo_q;
  logic [STEP_W-1:0]    qx_q;
  logic                 arrived_q;
  out_t                 out_q;

  logic                 in_acc;
  logic                 out_load;
  logic signed [CW:0]   dxw, dyw;
  logic [MW-1:0]        mul_a, mul_b;
  logic [RW+3:0]        sq_rsh, sq_trial;
  logic                 sq_take;
  logic [RW+1:0]        sqrem_d;
  logic [RW-1:0]        root_d;
  logic [RW:0]          dv_r2;
  logic                 dv_take;
  logic [RW-1:0]        drem_d;
  logic [STEP_W-1:0]    nlo_d;
  logic [CW-1:0]        qx_c, qy_c;
  logic [CW-1:0]        cur_x_d, cur_y_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_RES) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign dxw = (CW+1)'(dest_x_q) - (CW+1)'(cur_x_q);
  assign dyw = (CW+1)'(dest_y_q) - (CW+1)'(cur_y_q);

  // The one multiplier; its product is registered and read in the following state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MSTEP: begin
        mul_a = MW'(speed_q);
        mul_b = MW'(elapsed_q);
      end
      S_MSQX: begin
        mul_a = MW'(ax_q);
        mul_b = MW'(ax_q);
      end
      S_MSQY: begin
        mul_a = MW'(ay_q);
        mul_b = MW'(ay_q);
      end
      S_CMP: begin
        mul_a = MW'(step_q);
        mul_b = MW'(ax_q);
      end
      S_MULY: begin
        mul_a = MW'(step_q);
        mul_b = MW'(ay_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // One digit of the square root per cycle, two radicand bits at a time.
  always_comb begin
    sq_rsh   = {sqrem_q, rad_q[RADW-1 -: 2]};
    sq_trial = {2'b00, root_q, 2'b01};
    sq_take  = (sq_rsh >= sq_trial);
    sqrem_d  = sq_take ? (RW+2)'(sq_rsh - sq_trial) : (RW+2)'(sq_rsh);
    root_d   = {root_q[RW-2:0], sq_take};
  end

  // One quotient bit per cycle. The remainder stays below the distance because the quotient
  // never exceeds the step.
  always_comb begin
    dv_r2   = {drem_q, nlo_q[STEP_W-1]};
    dv_take = (dv_r2 >= {1'b0, root_q});
    drem_d  = dv_take ? RW'(dv_r2 - {1'b0, root_q}) : RW'(dv_r2);
    nlo_d   = {nlo_q[STEP_W-2:0], dv_take};
  end

  assign qx_c    = CW'(qx_q);
  assign qy_c    = CW'(nlo_d);
  assign cur_x_d = CW'(cur_x_q) + (negx_q ? CW'(-qx_c) : qx_c);
  assign cur_y_d = CW'(cur_y_q) + (negy_q ? CW'(-qy_c) : qy_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      div_y_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      dest_x_q    <= '0;
      dest_y_q    <= '0;
      moving_q    <= 1'b0;
      speed_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        speed_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_RES;
            unique case (in_data_i.func)
              FUNC_PLACE: begin
                cur_x_q  <= CW'(in_data_i.target_x);
                cur_y_q  <= CW'(in_data_i.target_y);
                dest_x_q <= CW'(in_data_i.target_x);
                dest_y_q <= CW'(in_data_i.target_y);
                moving_q <= 1'b0;
              end
              FUNC_GOTO: begin
                dest_x_q <= CW'(in_data_i.target_x);
                dest_y_q <= CW'(in_data_i.target_y);
                moving_q <= 1'b1;
              end
              FUNC_TICK: begin
                if (moving_q) begin
                  state_q <= S_MSTEP;
                end
              end
              default: begin
                state_q <= S_RES;
              end
            endcase
          end
        end
        S_MSTEP: state_q <= S_MSQX;
        S_MSQX:  state_q <= S_MSQY;
        S_MSQY:  state_q <= S_SUM;
        S_SUM: begin
          cnt_q   <= CNTW'(RW - 1);
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (ITW'(root_q) <= ITW'(step_q)) begin
            cur_x_q  <= dest_x_q;
            cur_y_q  <= dest_y_q;
            moving_q <= 1'b0;
            state_q  <= S_RES;
          end else begin
            state_q <= S_LDX;
          end
        end
        S_LDX, S_LDY: begin
          cnt_q   <= CNTW'(STEP_W - 1);
          div_y_q <= (state_q == S_LDY);
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            if (div_y_q) begin
              cur_x_q <= cur_x_d;
              cur_y_q <= cur_y_d;
              state_q <= S_RES;
            end else begin
              state_q <= S_MULY;
            end
          end
        end
        S_MULY: state_q <= S_LDY;
        S_RES: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      S_IDLE: begin
        arrived_q <= 1'b0;
        elapsed_q <= in_data_i.elapsed;
        ax_q      <= dxw[CW] ? CW'(-dxw) : CW'(dxw);
        ay_q      <= dyw[CW] ? CW'(-dyw) : CW'(dyw);
        negx_q    <= dxw[CW];
        negy_q    <= dyw[CW];
      end
      S_MSQX: step_q <= prod_q[FRAC_SHIFT +: STEP_W];
      S_MSQY: sum_q  <= SW'(prod_q);
      S_SUM: begin
        rad_q   <= RADW'(sum_q) + RADW'(prod_q);
        root_q  <= '0;
        sqrem_q <= '0;
      end
      S_SQRT: begin
        rad_q   <= {rad_q[RADW-3:0], 2'b00};
        sqrem_q <= sqrem_d;
        root_q  <= root_d;
      end
      S_CMP: begin
        arrived_q <= (ITW'(root_q) <= ITW'(step_q));
      end
      S_LDX, S_LDY: begin
        drem_q <= RW'(prod_q[NW-1:STEP_W]);
        nlo_q  <= prod_q[STEP_W-1:0];
      end
      S_DIV: begin
        drem_q <= drem_d;
        nlo_q  <= nlo_d;
        if (cnt_q == '0 && !div_y_q) begin
          qx_q <= nlo_d;
        end
      end
      S_RES: begin
        if (out_load) begin
          out_q.pos_x     <= IN_COORD_W'(cur_x_q);
          out_q.pos_y     <= IN_COORD_W'(cur_y_q);
          out_q.is_moving <= moving_q;
          out_q.arrived   <= arrived_q;
        end
      end
      default: begin
      end
    endcase
  end

  a_arrived_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.arrived |-> !out_data_o.is_moving)
    else $error("arrived reported while still moving");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.func == FUNC_TICK) && !moving_q
    |=> state_q == S_RES)
    else $error("tick while stopped did not go straight to the result");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> drem_q < root_q)
    else $error("divider remainder not below the distance");

  a_div_only_far: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LDX |-> ITW'(root_q) > ITW'(step_q))
    else $error("division started although the destination is within the step");

endmodule

### test/move_toward_target_step_top_tb.sv
// Self-checking testbench for the move toward target step block, with a built-in position predictor.
module move_toward_target_step_top_tb;
  import mtts_pkg::*;

  localparam int COORD_W = 24;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 100;

  logic clk;
  logic rst_n;
  logic cmd_valid;
  logic cmd_ready;
  in_t cmd_data;
  logic res_valid;
  logic res_ready;
  out_t res_data;
  logic cfg_we;
  logic [SPEED_W-1:0] cfg_wdata;

  // Predicted state of the moving point.
  logic signed [COORD_W-1:0] pt_x;
  logic signed [COORD_W-1:0] pt_y;
  logic signed [COORD_W-1:0] goal_x;
  logic signed [COORD_W-1:0] goal_y;
  logic travelling;
  logic [SPEED_W-1:0] speed_reg;

  out_t expected_pos[$];
  int fail_count;
  bit steady;
  int unsigned quiet_cycles;

  move_toward_target_step_top #(
    .COORD_WIDTH(COORD_W)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (cmd_valid),
    .in_ready_o (cmd_ready),
    .in_data_i  (cmd_data),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .out_data_o (res_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    longint unsigned rest;
    root = 0;
    rest = v;
    probe = 64'h1 << 62;
    while (probe > rest) probe >>= 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Applies one command to the predicted state and returns the position, moving flag and arrived flag it reports.
  function automatic out_t predict_position(in_t cmd);
    longint tx;
    longint ty;
    longint dx;
    longint dy;
    longint nx;
    longint ny;
    longint unsigned step;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned span;
    longint unsigned mx;
    longint unsigned my;
    logic hit;
    out_t res;
    tx = cmd.target_x;
    ty = cmd.target_y;
    hit = 1'b0;
    case (cmd.func)
      FUNC_PLACE: begin
        pt_x = tx[COORD_W-1:0];
        pt_y = ty[COORD_W-1:0];
        goal_x = tx[COORD_W-1:0];
        goal_y = ty[COORD_W-1:0];
        travelling = 1'b0;
      end
      FUNC_GOTO: begin
        goal_x = tx[COORD_W-1:0];
        goal_y = ty[COORD_W-1:0];
        travelling = 1'b1;
      end
      FUNC_TICK: begin
        if (travelling) begin
          step = (64'(speed_reg) * 64'(cmd.elapsed)) >> FRAC_SHIFT;
          dx = longint'(goal_x) - longint'(pt_x);
          dy = longint'(goal_y) - longint'(pt_y);
          ax = (dx < 0) ? -dx : dx;
          ay = (dy < 0) ? -dy : dy;
          span = int_sqrt(ax * ax + ay * ay);
          if (span <= step) begin
            pt_x = goal_x;
            pt_y = goal_y;
            travelling = 1'b0;
            hit = 1'b1;
          end else begin
            // Each axis moves by its share of the step, truncated toward zero.
            mx = step * ax / span;
            my = step * ay / span;
            nx = longint'(pt_x) + ((dx < 0) ? -longint'(mx) : longint'(mx));
            ny = longint'(pt_y) + ((dy < 0) ? -longint'(my) : longint'(my));
            pt_x = nx[COORD_W-1:0];
            pt_y = ny[COORD_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
    res.pos_x = pt_x;
    res.pos_y = pt_y;
    res.is_moving = travelling;
    res.arrived = hit;
    return res;
  endfunction

  task automatic send_cmd(input logic [1:0] func, input logic [23:0] x, input logic [23:0] y,
                          input logic [15:0] el);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      cmd_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_data.func = func;
    cmd_data.target_x = x;
    cmd_data.target_y = y;
    cmd_data.elapsed = el;
    cmd_valid = 1'b1;
    do @(posedge clk); while (!cmd_ready);
    expected_pos.push_back(predict_position(cmd_data));
    @(negedge clk);
  endtask

  // Waits until every outstanding transaction has been checked and the block is idle.
  task automatic settle();
    cmd_valid = 1'b0;
    while (expected_pos.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_speed(input logic [SPEED_W-1:0] value);
    settle();
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    speed_reg = value;
  endtask

  function automatic logic [23:0] near_offset();
    int k;
    int unsigned off;
    k = $urandom_range(0, 23);
    off = $urandom_range(0, 1 << k);
    return $urandom_range(0, 1) ? 24'(-off) : 24'(off);
  endfunction

  task automatic test_stopped_and_nop();
    send_cmd(FUNC_TICK, 24'hFFFFFF, 24'h800000, 16'hFFFF);
    send_cmd(FUNC_NOP, 24'h7FFFFF, 24'h123456, 16'hFFFF);
  endtask

  // Speed is still zero from reset, so a moving point cannot advance.
  task automatic test_zero_step();
    send_cmd(FUNC_PLACE, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF);
    send_cmd(FUNC_GOTO, 24'h800000, 24'h800000, 16'hFFFF);
    send_cmd(FUNC_TICK, 24'h000000, 24'h000000, 16'hFFFF);
    send_cmd(FUNC_TICK, 24'hFFFFFF, 24'hFFFFFF, 16'h0000);
  endtask

  task automatic test_full_range();
    set_speed(24'hFFFFFF);
    send_cmd(FUNC_TICK, 24'h000000, 24'h000000, 16'hFFFF);
    send_cmd(FUNC_TICK, 24'h000000, 24'h000000, 16'hFFFF);
    // A destination on the current position arrives even with no step.
    send_cmd(FUNC_GOTO, pt_x, pt_y, 16'h0000);
    send_cmd(FUNC_TICK, 24'h000000, 24'h000000, 16'h0000);
    send_cmd(FUNC_PLACE, 24'h800000, 24'h7FFFFF, 16'h0000);
    send_cmd(FUNC_GOTO, 24'h7FFFFF, 24'h7FFFFF, 16'h0000);
    send_cmd(FUNC_TICK, 24'h000000, 24'h000000, 16'h0001);
  endtask

  task automatic test_fractional_step();
    set_speed(24'h000100);
    send_cmd(FUNC_PLACE, 24'h000000, 24'h000000, 16'h0000);
    send_cmd(FUNC_GOTO, -24'sd1000, 24'sd333, 16'h0000);
    send_cmd(FUNC_TICK, 24'h555555, 24'hAAAAAA, 16'h8000);
    send_cmd(FUNC_TICK, 24'h000000, 24'h000000, 16'h0000);
    send_cmd(FUNC_TICK, 24'h000000, 24'h000000, 16'hFFFF);
    send_cmd(FUNC_PLACE, -24'sd5, 24'sd7, 16'hFFFF);
    send_cmd(FUNC_GOTO, -24'sd2, 24'sd3, 16'hFFFF);
    send_cmd(FUNC_TICK, 24'hFFFFFF, 24'hFFFFFF, 16'h0500);
  endtask

  // Mostly place, go-to and tick sequences toward near or far destinations, with some noise.
  task automatic test_random_travel(input logic [SPEED_W-1:0] spd, input int n,
                                    input bit no_idle);
    int sent;
    int ticks;
    logic [23:0] gx;
    logic [23:0] gy;
    logic [15:0] el;
    set_speed(spd);
    steady = no_idle;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 8) begin
        send_cmd(2'($urandom_range(0, 3)), 24'($urandom), 24'($urandom), 16'($urandom));
        sent++;
      end else begin
        if ($urandom_range(0, 1)) begin
          send_cmd(FUNC_PLACE, 24'($urandom), 24'($urandom), 16'($urandom));
          sent++;
        end
        if ($urandom_range(0, 1)) begin
          gx = 24'($urandom);
          gy = 24'($urandom);
        end else begin
          gx = pt_x + near_offset();
          gy = pt_y + near_offset();
        end
        send_cmd(FUNC_GOTO, gx, gy, 16'($urandom));
        sent++;
        ticks = $urandom_range(1, 12);
        repeat (ticks) begin
          if (travelling || $urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
              0: el = 16'($urandom);
              1: el = 16'($urandom_range(0, 16'h00FF));
              2: el = 16'hFFFF;
              default: el = 16'($urandom_range(0, 16'h0FFF));
            endcase
            send_cmd(FUNC_TICK, 24'($urandom), 24'($urandom), el);
            sent++;
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          send_cmd(FUNC_NOP, 24'($urandom), 24'($urandom), 16'($urandom));
          sent++;
        end
      end
    end
    steady = 1'b0;
  endtask

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  initial begin : result_monitor
    out_t want;
    int stall;
    res_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        res_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ready = 1'b1;
      do @(posedge clk); while (!res_valid);
      if (expected_pos.size() == 0) begin
        $error("result transaction with no command pending: 0x%0h", res_data);
        fail_count++;
      end else begin
        want = expected_pos.pop_front();
        check_field("pos_x", want.pos_x, res_data.pos_x);
        check_field("pos_y", want.pos_y, res_data.pos_y);
        check_field("is_moving", want.is_moving, res_data.is_moving);
        check_field("arrived", want.arrived, res_data.arrived);
      end
      @(negedge clk);
    end
  end

  // Ends the run when no transaction completes on either side for too long.
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    cmd_valid = 1'b0;
    cmd_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    steady = 1'b0;
    fail_count = 0;
    pt_x = '0;
    pt_y = '0;
    goal_x = '0;
    goal_y = '0;
    travelling = 1'b0;
    speed_reg = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_stopped_and_nop();
    test_zero_step();
    test_full_range();
    test_fractional_step();
    test_random_travel(24'hFFFFFF, 200, 1'b0);
    test_random_travel(24'($urandom), 200, 1'b0);
    test_random_travel(24'($urandom_range(1, 24'h000FFF)), 200, 1'b1);
    test_random_travel(24'h000000, 150, 1'b0);
    test_random_travel(24'h010000 >> $urandom_range(0, 16), 200, 1'b0);
    test_random_travel(24'($urandom), 250, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_pos.size() != 0) begin
      $error("%0d expected results never arrived", expected_pos.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
